/* design/crc8_command_frame_receiver_top_defines.svh */
// Assertion macros for the CRC-8 command frame receiver.
// Used by crc8_command_frame_receiver_top; no other dependencies.
`ifndef CRC8_COMMAND_FRAME_RECEIVER_TOP_DEFINES_SVH
`define CRC8_COMMAND_FRAME_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CFR_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("cfr assertion failed");

// Next-cycle implication, checked outside reset.
`define CFR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("cfr assertion failed");

`endif

/* design/crc8cfr_pkg.sv */
// Shared constants and functions for the CRC-8 command frame receiver.
// No dependencies.
package crc8cfr_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'h1e;
  localparam logic [7:0] CRC_POLY_REFL = 8'h8c;

  localparam logic [7:0] CMD_01 = 8'h01;
  localparam logic [7:0] CMD_02 = 8'h02;
  localparam logic [7:0] CMD_03 = 8'h03;
  localparam logic [7:0] CMD_04 = 8'h04;
  localparam logic [7:0] CMD_05 = 8'h05;
  localparam logic [7:0] CMD_06 = 8'h06;
  localparam logic [7:0] CMD_07 = 8'h07;
  localparam logic [7:0] CMD_08 = 8'h08;

  localparam logic [1:0] ST_PENDING = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_GOOD    = 2'd2;
  localparam logic [1:0] ST_CRC_ERR = 2'd3;

  localparam logic [2:0] LEN_NONE  = 3'd0;
  localparam logic [2:0] LEN_SHORT = 3'd3;
  localparam logic [2:0] LEN_ONE   = 3'd4;
  localparam logic [2:0] LEN_THREE = 3'd6;
  localparam logic [2:0] LEN_FOUR  = 3'd7;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [2:0] frame_len_of(input logic [7:0] cmd);
    logic [2:0] len;
    case (cmd) inside
      CMD_01, CMD_03, CMD_05, CMD_06, CMD_08: len = LEN_SHORT;
      CMD_02: len = LEN_ONE;
      CMD_04: len = LEN_THREE;
      CMD_07: len = LEN_FOUR;
      default: len = LEN_NONE;
    endcase
    return len;
  endfunction

endpackage

/* design/crc8_command_frame_receiver_top.sv */
// Output: the status beat of an accepted byte is registered and valid in the next cycle.
// Throughput: one byte per cycle unless stalled; the frame state and CRC update are
// resolved in a single pass between the input handshake and the result register.
// Reset: synchronous, active high; clears the frame state and the result valid.
// Depends on crc8cfr_pkg and crc8_command_frame_receiver_top_defines.svh.
`include "crc8_command_frame_receiver_top_defines.svh"

module crc8_command_frame_receiver_top
  import crc8cfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  frame_status,
  output logic [7:0]  command_code,
  output logic [31:0] payload_word,
  output logic [2:0]  payload_length
);

  logic [2:0]  byte_count, byte_count_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [2:0]  frame_length, frame_length_next;
  logic [7:0]  held_command, held_command_next;
  logic [31:0] payload_store, payload_store_next;

  logic [1:0]  status_next;
  logic [7:0]  cmd_next;
  logic [31:0] word_next;
  logic [2:0]  len_next;

  logic        accept;
  logic [2:0]  lookup_len;
  logic [7:0]  crc_in;
  logic [1:0]  slot;
  logic [3:0]  count_plus1;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign lookup_len  = frame_len_of(rx_byte);
  assign crc_in      = crc8_update(running_crc, rx_byte);
  assign slot        = 2'(byte_count - 3'd2);
  assign count_plus1 = {1'b0, byte_count} + 4'd1;

  always_comb begin
    byte_count_next    = byte_count;
    running_crc_next   = running_crc;
    frame_length_next  = frame_length;
    held_command_next  = held_command;
    payload_store_next = payload_store;
    status_next        = ST_PENDING;
    cmd_next           = '0;
    word_next          = '0;
    len_next           = '0;
    if (byte_count == 3'd0) begin
      if (rx_byte != HEADER_BYTE) begin
        status_next = ST_DROPPED;
      end else begin
        running_crc_next = crc_in;
        byte_count_next  = 3'd1;
      end
    end else if (byte_count == 3'd1) begin
      if (lookup_len == LEN_NONE) begin
        status_next        = ST_DROPPED;
        byte_count_next    = '0;
        running_crc_next   = '0;
        frame_length_next  = '0;
        held_command_next  = '0;
        payload_store_next = '0;
      end else begin
        held_command_next  = rx_byte;
        frame_length_next  = lookup_len;
        running_crc_next   = crc_in;
        payload_store_next = '0;
        byte_count_next    = 3'd2;
      end
    end else if (count_plus1 >= {1'b0, frame_length}) begin
      cmd_next = held_command;
      if (rx_byte == running_crc) begin
        status_next = ST_GOOD;
        word_next   = payload_store;
        len_next    = frame_length - LEN_SHORT;
      end else begin
        status_next = ST_CRC_ERR;
      end
      byte_count_next    = '0;
      running_crc_next   = '0;
      frame_length_next  = '0;
      held_command_next  = '0;
      payload_store_next = '0;
    end else begin
      payload_store_next = payload_store | ({24'd0, rx_byte} << {slot, 3'b000});
      running_crc_next   = crc_in;
      byte_count_next    = count_plus1[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      running_crc   <= '0;
      frame_length  <= '0;
      held_command  <= '0;
      payload_store <= '0;
    end else if (accept) begin
      byte_count    <= byte_count_next;
      running_crc   <= running_crc_next;
      frame_length  <= frame_length_next;
      held_command  <= held_command_next;
      payload_store <= payload_store_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frame_status   <= status_next;
      command_code   <= cmd_next;
      payload_word   <= word_next;
      payload_length <= len_next;
    end
  end

  `CFR_ASSERT_IMPL(a_idle_fields_zero, clk, rst,
    out_valid && (frame_status == ST_PENDING || frame_status == ST_DROPPED),
    command_code == 8'd0 && payload_word == 32'd0 && payload_length == 3'd0)
  `CFR_ASSERT_IMPL(a_len_only_good, clk, rst,
    out_valid && payload_length != 3'd0, frame_status == ST_GOOD)
  `CFR_ASSERT_IMPL(a_count_in_frame, clk, rst,
    byte_count >= 3'd2, frame_length >= LEN_SHORT && byte_count < frame_length)
  `CFR_ASSERT_NEXT(a_bad_header_resync, clk, rst,
    accept && byte_count == 3'd0 && rx_byte != HEADER_BYTE,
    byte_count == 3'd0 && out_valid && frame_status == ST_DROPPED)

endmodule

/* tb/sv/crc8_command_frame_receiver_checker.sv */
// Scoreboard for the CRC-8 command frame receiver: watches both channels,
// predicts one status beat per accepted byte and compares in order.
// Depends on crc8cfr_pkg for the header, command, status and length codes and the CRC polynomial.
module crc8_command_frame_receiver_checker
  import crc8cfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  frame_status,
  input  logic [7:0]  command_code,
  input  logic [31:0] payload_word,
  input  logic [2:0]  payload_length,
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  cmd;
    logic [31:0] word;
    logic [2:0]  len;
  } status_beat_t;

  status_beat_t status_queue[$];

  logic [2:0]  rx_count;
  logic [7:0]  crc_acc;
  logic [2:0]  frame_len;
  logic [7:0]  cmd_hold;
  logic [31:0] payload_acc;

  function automatic logic [7:0] maxim_crc_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    return c;
  endfunction

  function automatic logic [2:0] frame_len_for(input logic [7:0] cmd);
    case (cmd)
      CMD_01, CMD_03, CMD_05, CMD_06, CMD_08: return LEN_SHORT;
      CMD_02: return LEN_ONE;
      CMD_04: return LEN_THREE;
      CMD_07: return LEN_FOUR;
      default: return LEN_NONE;
    endcase
  endfunction

  task automatic clear_frame();
    rx_count = '0;
    crc_acc = '0;
    frame_len = '0;
    cmd_hold = '0;
    payload_acc = '0;
  endtask

  task automatic predict_status(input logic [7:0] b, output status_beat_t r);
    logic [2:0] len;
    logic [1:0] idx;
    r = '0;
    r.status = ST_PENDING;
    if (rx_count == 3'd0) begin
      if (b != HEADER_BYTE) begin
        clear_frame();
        r.status = ST_DROPPED;
      end else begin
        crc_acc = maxim_crc_step(8'h00, b);
        rx_count = 3'd1;
      end
    end else if (rx_count == 3'd1) begin
      len = frame_len_for(b);
      if (len == LEN_NONE) begin
        clear_frame();
        r.status = ST_DROPPED;
      end else begin
        cmd_hold = b;
        frame_len = len;
        crc_acc = maxim_crc_step(crc_acc, b);
        payload_acc = '0;
        rx_count = 3'd2;
      end
    end else if (int'(rx_count) + 1 >= int'(frame_len)) begin
      r.cmd = cmd_hold;
      if (b == crc_acc) begin
        r.status = ST_GOOD;
        r.word = payload_acc;
        r.len = frame_len - 3'd3;
      end else begin
        r.status = ST_CRC_ERR;
      end
      clear_frame();
    end else begin
      idx = 2'(rx_count - 3'd2);
      payload_acc = payload_acc | (32'(b) << (8 * int'(idx)));
      crc_acc = maxim_crc_step(crc_acc, b);
      rx_count = rx_count + 3'd1;
    end
  endtask

  always @(posedge clk) begin
    int errs;
    status_beat_t want;
    status_beat_t got;
    if (rst) begin
      clear_frame();
      status_queue.delete();
      fail_count <= 0;
      outstanding <= 0;
    end else begin
      errs = 0;
      if (out_valid && out_ready) begin
        got = {frame_status, command_code, payload_word, payload_length};
        if (status_queue.size() == 0) begin
          $error("status beat with nothing expected: frame_status %0d", frame_status);
          errs++;
        end else begin
          want = status_queue.pop_front();
          if (got.status !== want.status) begin
            $error("frame_status expected %0d actual %0d", want.status, got.status);
            errs++;
          end
          if (got.cmd !== want.cmd) begin
            $error("command_code expected 0x%02h actual 0x%02h", want.cmd, got.cmd);
            errs++;
          end
          if (got.word !== want.word) begin
            $error("payload_word expected 0x%08h actual 0x%08h", want.word, got.word);
            errs++;
          end
          if (got.len !== want.len) begin
            $error("payload_length expected %0d actual %0d", want.len, got.len);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_status(rx_byte, want);
        status_queue.push_back(want);
      end
      fail_count <= fail_count + errs;
      outstanding <= status_queue.size();
    end
  end

endmodule

/* tb/sv/crc8_command_frame_receiver_top_tb.sv */
// Top of the CRC-8 command frame receiver testbench: clock, reset, byte
// stimulus with random idling and stalls, watchdog and verdict.
// Depends on crc8cfr_pkg, the receiver RTL and crc8_command_frame_receiver_checker.
module crc8_command_frame_receiver_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import crc8cfr_pkg::*;

  localparam int STIM_BYTES = 700;
  localparam int PHASES = 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  frame_status;
  logic [7:0]  command_code;
  logic [31:0] payload_word;
  logic [2:0]  payload_length;

  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;
  int fail_count;
  int outstanding;
  int phase_idle[PHASES] = '{0, 66, 0, 31};
  int phase_stall[PHASES] = '{0, 0, 66, 31};

  always #10ns clk = ~clk;

  crc8_command_frame_receiver_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_status   (frame_status),
    .command_code   (command_code),
    .payload_word   (payload_word),
    .payload_length (payload_length)
  );

  crc8_command_frame_receiver_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_status   (frame_status),
    .command_code   (command_code),
    .payload_word   (payload_word),
    .payload_length (payload_length),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** crc8_command_frame_receiver_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  function automatic logic [7:0] payload_pick();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // Build header, command, body and CRC; flip corrupts the CRC, keep truncates.
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] body[$],
                            input logic [7:0] flip, input int keep);
    logic [7:0] q[$];
    logic [7:0] crc;
    q = {HEADER_BYTE, cmd};
    q = {q, body};
    crc = 8'h00;
    foreach (q[i]) crc = crc8_update(crc, q[i]);
    q.push_back(crc ^ flip);
    while (q.size() > keep) void'(q.pop_back());
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic random_frame();
    int kind;
    int keep;
    logic [7:0] cmd;
    logic [7:0] flip;
    logic [7:0] body[$];
    kind = $urandom_range(99);
    if (kind < 8) begin
      send_byte(8'($urandom));
    end else if (kind < 14) begin
      do cmd = 8'($urandom); while (frame_len_of(cmd) != LEN_NONE);
      send_byte(HEADER_BYTE);
      send_byte(cmd);
    end else begin
      cmd = 8'($urandom_range(int'(CMD_01), int'(CMD_08)));
      repeat (int'(frame_len_of(cmd)) - 3) body.push_back(payload_pick());
      flip = (kind < 32) ? 8'($urandom_range(1, 255)) : 8'h00;
      keep = (kind >= 32 && kind < 37) ? $urandom_range(1, int'(frame_len_of(cmd)) - 1) : 8;
      send_frame(cmd, body, flip, keep);
    end
  endtask

  initial begin
    logic [7:0] body[$];
    int target;
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'hff);
    send_byte(HEADER_BYTE);
    send_byte(8'h00);
    send_byte(HEADER_BYTE);
    send_byte(HEADER_BYTE);
    body = {8'h00, 8'hff, 8'h80, 8'h01};
    send_frame(CMD_07, body, 8'h00, 8);
    body = {8'hff, 8'h00, 8'h7f};
    send_frame(CMD_04, body, 8'h00, 8);
    body = {8'h5a};
    send_frame(CMD_02, body, 8'h01, 8);
    body = {};
    send_frame(CMD_08, body, 8'h00, 8);

    for (int p = 0; p < PHASES; p++) begin
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      target = bytes_sent + STIM_BYTES / PHASES;
      while (bytes_sent < target) random_frame();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("** crc8_command_frame_receiver_top: PASSED **");
    end else begin
      $display("** crc8_command_frame_receiver_top: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/crc8cfr_pkg.sv
design/crc8_command_frame_receiver_top.sv
tb/sv/crc8_command_frame_receiver_checker.sv
tb/sv/crc8_command_frame_receiver_top_tb.sv
